@@ rtl/core/prv_pkg.sv @@
// Shared widths and the pipeline record type for the pair radial velocity block.
package prv_pkg;

  localparam int DW    = 36;   // folded displacement, signed
  localparam int MW    = 33;   // component magnitude
  localparam int PW    = 66;   // component product
  localparam int SW    = 68;   // squared length, dot product
  localparam int HW    = 34;   // dot product half for partial products
  localparam int PPW   = 67;   // partial product
  localparam int NUMW  = 101;  // dot * |d_k|
  localparam int NW    = 104;  // rounded dividend
  localparam int DENW  = 69;   // divisor, 2 * squared length
  localparam int QW    = 35;   // quotient bits below the overflow check
  localparam int RW    = 70;   // root remainder
  localparam int RTW   = 35;   // root
  localparam int EARLY = 11;   // stages before the bit iterations
  localparam int ITER  = 35;   // one quotient bit and one root bit per stage
  localparam int NST   = EARLY + ITER + 1;

  localparam logic [32:0] LIM_POS = 33'h07FFFFFFF;
  localparam logic [32:0] LIM_NEG = 33'h080000000;

  typedef struct packed {
    logic [2:0][NW-1:0] n;
    logic [2:0][QW-1:0] q;
    logic [2:0]         neg;
    logic [2:0]         ovf;
    logic [DENW-1:0]    den;
    logic [RW-1:0]      rem;
    logic [RTW-1:0]     root;
    logic               zero;
  } it_t;

endpackage

@@ rtl/core/prv_if.sv @@
// Request channel interfaces: particle pair in, projected velocity out.
interface prv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_a_x;
  logic signed [31:0] pos_a_y;
  logic signed [31:0] pos_a_z;
  logic signed [31:0] pos_b_x;
  logic signed [31:0] pos_b_y;
  logic signed [31:0] pos_b_z;
  logic signed [31:0] vel_a_x;
  logic signed [31:0] vel_a_y;
  logic signed [31:0] vel_a_z;
  logic signed [31:0] vel_b_x;
  logic signed [31:0] vel_b_y;
  logic signed [31:0] vel_b_z;

  modport source (
    output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
           vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
    input  ready
  );
  modport sink (
    input  valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
           vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
    output ready
  );
endinterface

interface prv_out_if;
  logic               valid;
  logic               ready;
  logic [30:0]        pair_distance;
  logic signed [31:0] radial_vel_x;
  logic signed [31:0] radial_vel_y;
  logic signed [31:0] radial_vel_z;
  logic               coincident;
  logic               saturated;

  modport source (
    output valid, pair_distance, radial_vel_x, radial_vel_y, radial_vel_z,
           coincident, saturated,
    input  ready
  );
  modport sink (
    input  valid, pair_distance, radial_vel_x, radial_vel_y, radial_vel_z,
           coincident, saturated,
    output ready
  );
endinterface

@@ rtl/core/periodic_pair_radial_velocity.sv @@
// Minimum-image pair distance and radial relative velocity, fully pipelined.
// One pair request is taken per clock while in_ch.ready is high; ready drops
// only when the output side stalls a full pipeline. The pipeline has eleven
// stages of fold, multiply and sum, then 35 stages that each resolve
// one bit of the three rounded quotients and one bit of the integer square
// root, then the output register. Each stage holds while the one after it is
// full and stalled, so bubbles close up and nothing is lost or repeated.
// box_length sits at address 0 of the APB port (reset 16.0 in Q16.16).
module periodic_pair_radial_velocity (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [0:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  prv_in_if.sink             in_ch,
  prv_out_if.source          out_ch
);

  localparam int NST = prv_pkg::NST;
  localparam int EA  = prv_pkg::EARLY;
  localparam int IT  = prv_pkg::ITER;

  logic [30:0]    box_r;
  logic [NST-1:0] vld_r;
  logic [NST:0]   rdy;

  // config
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? {1'b0, box_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= 31'd1048576;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0) begin
      box_r <= cfg_pwdata[30:0];
    end
  end

  // valid / ready chain
  always_comb begin
    rdy[NST] = out_ch.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // s1: differences
  logic signed [prv_pkg::DW-1:0] pa [3], pb [3], va [3], vb [3];
  logic signed [prv_pkg::DW-1:0] d1_r [3], v1_r [3];

  assign pa[0] = prv_pkg::DW'(in_ch.pos_a_x);
  assign pa[1] = prv_pkg::DW'(in_ch.pos_a_y);
  assign pa[2] = prv_pkg::DW'(in_ch.pos_a_z);
  assign pb[0] = prv_pkg::DW'(in_ch.pos_b_x);
  assign pb[1] = prv_pkg::DW'(in_ch.pos_b_y);
  assign pb[2] = prv_pkg::DW'(in_ch.pos_b_z);
  assign va[0] = prv_pkg::DW'(in_ch.vel_a_x);
  assign va[1] = prv_pkg::DW'(in_ch.vel_a_y);
  assign va[2] = prv_pkg::DW'(in_ch.vel_a_z);
  assign vb[0] = prv_pkg::DW'(in_ch.vel_b_x);
  assign vb[1] = prv_pkg::DW'(in_ch.vel_b_y);
  assign vb[2] = prv_pkg::DW'(in_ch.vel_b_z);

  logic signed [prv_pkg::DW-1:0] len;
  assign len = signed'({5'd0, box_r});

  // s2..s4: fold, magnitudes
  logic signed [prv_pkg::DW-1:0] d2_r [3], v2_r [3], d3_r [3], v3_r [3];
  logic [prv_pkg::MW-1:0] md4_r [3], mv4_r [3];
  logic [2:0] sd4_r, sv4_r;
  // s5: products
  logic [prv_pkg::PW-1:0] pdd5_r [3], pdv5_r [3];
  logic [prv_pkg::MW-1:0] md5_r [3];
  logic [2:0] sd5_r, x5_r;
  // s6: sums
  logic [prv_pkg::SW-1:0] sq6_r, dpos6_r, dneg6_r;
  logic [prv_pkg::MW-1:0] md6_r [3];
  logic [2:0] sd6_r;
  // s7: signed dot
  logic [prv_pkg::SW-1:0] sq7_r, dotm7_r;
  logic [prv_pkg::MW-1:0] md7_r [3];
  logic [2:0] neg7_r;
  // s8: partial products
  logic [prv_pkg::PPW-1:0] pl8_r [3], ph8_r [3];
  logic [prv_pkg::SW-1:0] sq8_r;
  logic [2:0] neg8_r;
  // s9: numerators
  logic [prv_pkg::NUMW-1:0] num9_r [3];
  logic [prv_pkg::SW-1:0] sq9_r;
  logic [2:0] neg9_r;
  // s10: rounded dividends
  logic [prv_pkg::NW-1:0] n10_r [3];
  logic [prv_pkg::SW-1:0] sq10_r;
  logic [2:0] neg10_r;

  logic [prv_pkg::SW-1:0] dpos_nxt, dneg_nxt;
  always_comb begin
    dpos_nxt = '0;
    dneg_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      if (x5_r[k]) dneg_nxt = dneg_nxt + prv_pkg::SW'(pdv5_r[k]);
      else         dpos_nxt = dpos_nxt + prv_pkg::SW'(pdv5_r[k]);
    end
  end

  prv_pkg::it_t it_r [IT+1];
  prv_pkg::it_t it_nxt [IT+1];

  always_comb begin
    it_nxt[0] = '0;
    for (int k = 0; k < 3; k++) begin
      it_nxt[0].n[k]   = n10_r[k];
      it_nxt[0].ovf[k] = n10_r[k][prv_pkg::NW-1:prv_pkg::QW] >= {sq10_r, 1'b0};
    end
    it_nxt[0].neg  = neg10_r;
    it_nxt[0].den  = {sq10_r, 1'b0};
    it_nxt[0].rem  = prv_pkg::RW'(sq10_r);
    it_nxt[0].zero = (sq10_r == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k] <= pa[k] - pb[k];
        v1_r[k] <= va[k] - vb[k];
      end
    end
    if (rdy[1]) begin
      for (int k = 0; k < 3; k++) begin
        d2_r[k] <= ((d1_r[k] <<< 1) > len) ? d1_r[k] - len : d1_r[k];
        v2_r[k] <= v1_r[k];
      end
    end
    if (rdy[2]) begin
      for (int k = 0; k < 3; k++) begin
        d3_r[k] <= ((d2_r[k] <<< 1) < -len) ? d2_r[k] + len : d2_r[k];
        v3_r[k] <= v2_r[k];
      end
    end
    if (rdy[3]) begin
      for (int k = 0; k < 3; k++) begin
        md4_r[k] <= prv_pkg::MW'(d3_r[k] < 0 ? -d3_r[k] : d3_r[k]);
        mv4_r[k] <= prv_pkg::MW'(v3_r[k] < 0 ? -v3_r[k] : v3_r[k]);
        sd4_r[k] <= d3_r[k] < 0;
        sv4_r[k] <= v3_r[k] < 0;
      end
    end
    if (rdy[4]) begin
      for (int k = 0; k < 3; k++) begin
        pdd5_r[k] <= md4_r[k] * md4_r[k];
        pdv5_r[k] <= md4_r[k] * mv4_r[k];
        md5_r[k]  <= md4_r[k];
      end
      sd5_r <= sd4_r;
      x5_r  <= sd4_r ^ sv4_r;
    end
    if (rdy[5]) begin
      sq6_r   <= prv_pkg::SW'(pdd5_r[0]) + prv_pkg::SW'(pdd5_r[1])
               + prv_pkg::SW'(pdd5_r[2]);
      dpos6_r <= dpos_nxt;
      dneg6_r <= dneg_nxt;
      md6_r   <= md5_r;
      sd6_r   <= sd5_r;
    end
    if (rdy[6]) begin
      sq7_r   <= sq6_r;
      md7_r   <= md6_r;
      dotm7_r <= (dneg6_r > dpos6_r) ? dneg6_r - dpos6_r : dpos6_r - dneg6_r;
      neg7_r  <= sd6_r ^ {3{dneg6_r > dpos6_r}};
    end
    if (rdy[7]) begin
      for (int k = 0; k < 3; k++) begin
        pl8_r[k] <= dotm7_r[prv_pkg::HW-1:0] * md7_r[k];
        ph8_r[k] <= dotm7_r[prv_pkg::SW-1:prv_pkg::HW] * md7_r[k];
      end
      sq8_r  <= sq7_r;
      neg8_r <= neg7_r;
    end
    if (rdy[8]) begin
      for (int k = 0; k < 3; k++) begin
        num9_r[k] <= (prv_pkg::NUMW'(ph8_r[k]) << prv_pkg::HW) + prv_pkg::NUMW'(pl8_r[k]);
      end
      sq9_r  <= sq8_r;
      neg9_r <= neg8_r;
    end
    if (rdy[9]) begin
      for (int k = 0; k < 3; k++) begin
        n10_r[k] <= {2'b0, num9_r[k], 1'b0} + prv_pkg::NW'(sq9_r);
      end
      sq10_r  <= sq9_r;
      neg10_r <= neg9_r;
    end
    if (rdy[10]) begin
      it_r[0] <= it_nxt[0];
    end
  end

  // s12..s46: one quotient bit per lane and one root bit per stage
  for (genvar j = 0; j < IT; j++) begin : g_it
    localparam int B = prv_pkg::QW - 1 - j;
    logic [prv_pkg::NW-1:0] sh;
    logic [prv_pkg::RW-1:0] trial;

    assign sh    = prv_pkg::NW'(it_r[j].den) << B;
    assign trial = (prv_pkg::RW'(it_r[j].root) << (B + 1)) + (prv_pkg::RW'(1) << (2 * B));

    always_comb begin
      it_nxt[j+1] = it_r[j];
      for (int k = 0; k < 3; k++) begin
        if (it_r[j].n[k] >= sh) begin
          it_nxt[j+1].n[k]    = it_r[j].n[k] - sh;
          it_nxt[j+1].q[k][B] = 1'b1;
        end
      end
      if (it_r[j].rem >= trial) begin
        it_nxt[j+1].rem     = it_r[j].rem - trial;
        it_nxt[j+1].root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[EA+j]) begin
        it_r[j+1] <= it_nxt[j+1];
      end
    end
  end

  // output register
  prv_pkg::it_t fin;
  logic [2:0][31:0] rv_nxt;
  logic [2:0]       sat_nxt;
  logic [32:0]      lim, m;

  assign fin = it_r[IT];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lim = fin.neg[k] ? prv_pkg::LIM_NEG : prv_pkg::LIM_POS;
      sat_nxt[k] = fin.ovf[k] || (fin.q[k] > prv_pkg::QW'(lim));
      m = sat_nxt[k] ? lim : fin.q[k][32:0];
      rv_nxt[k] = fin.neg[k] ? 32'(-m) : m[31:0];
      if (fin.zero) rv_nxt[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      out_ch.pair_distance <= fin.zero ? '0 :
                              (fin.root > prv_pkg::RTW'(31'h7FFFFFFF)) ? 31'h7FFFFFFF :
                              fin.root[30:0];
      out_ch.radial_vel_x  <= rv_nxt[0];
      out_ch.radial_vel_y  <= rv_nxt[1];
      out_ch.radial_vel_z  <= rv_nxt[2];
      out_ch.coincident    <= fin.zero;
      out_ch.saturated     <= !fin.zero && (|sat_nxt);
    end
  end

endmodule
